[sv/pths_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probe touch homing sequencer package
// Command codes, configuration register indexes, result targets and port
// constants that are shared by the sequencer and its users.
// ----------------------------------------------------------------------------
package pths_pkg;

    localparam int KIND_WIDTH      = 3;
    localparam int MODE_WIDTH      = 2;
    localparam int TARGET_WIDTH    = 2;
    localparam int MODE_REQ_WIDTH  = 2;
    localparam int CFG_ADDR_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int TOL_WIDTH       = 15;

    localparam logic [KIND_WIDTH-1:0] KIND_TICK       = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_HOME       = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_SEARCH_MIN = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_MEASURE    = 3'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_RESET      = 3'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_INIT       = 3'd5;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_TIMEOUT_TICKS  = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_TOUCH_TOL      = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MEASURE_SETTLE = 2'd2;

    localparam logic [CFG_DATA_WIDTH-1:0] TIMEOUT_TICKS_RESET  = 16'd200;
    localparam logic [TOL_WIDTH-1:0]      TOUCH_TOL_RESET      = 15'd0;
    localparam logic [CFG_DATA_WIDTH-1:0] MEASURE_SETTLE_RESET = 16'd500;

    localparam logic [MODE_WIDTH-1:0] MODE_SELF_LEARN  = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_CALIBRATION = 2'd2;

    localparam logic [TARGET_WIDTH-1:0] TARGET_NONE        = 2'd0;
    localparam logic [TARGET_WIDTH-1:0] TARGET_ZERO_OFFSET = 2'd1;
    localparam logic [TARGET_WIDTH-1:0] TARGET_MIN_POS     = 2'd2;
    localparam logic [TARGET_WIDTH-1:0] TARGET_MOULD_DEPTH = 2'd3;

    localparam logic [MODE_REQ_WIDTH-1:0] MODE_REQ_NONE        = 2'd0;
    localparam logic [MODE_REQ_WIDTH-1:0] MODE_REQ_SELF_LEARN  = 2'd1;
    localparam logic [MODE_REQ_WIDTH-1:0] MODE_REQ_CALIBRATION = 2'd2;

endpackage

[sv/probe_touch_homing_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probe touch homing sequencer
// Drives a touch probe through home, search-minimum and measure sequences
// from a stream of commands and position ticks, one result per item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Content
//  s_axis    in         s_axis_tvalid/tready    command or tick with positions
//  m_axis    out        m_axis_tvalid/tready    drive, flags, store request
//  cfg       in         cfg_valid/cfg_ready     register index and write data
//
//  Each item is held in the input register and is evaluated on its
//  way into the result register, so one item per cycle is sustained
//  while the output is not stalled. The result is held valid in the
//  result register until it is taken.
//  Reset returns the sequence to idle with the configuration at its defaults.
//  A stalled output holds its result; both stages still fill before the
//  input side deasserts ready. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module probe_touch_homing_sequencer #(
    parameter int POSITION_WIDTH = 32,
    parameter int TIMER_WIDTH    = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // kind
    input  logic [pths_pkg::KIND_WIDTH-1:0]          s_axis_tuser,
    // abs_position, rel_position, mm_position, machine_mode, flash_idle
    input  logic [8*((3*POSITION_WIDTH+3+7)/8)-1:0]  s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // probe_drive, homing_done, homing_alarm, store_target, store_position,
    // store_mm, save_request, mode_request
    output logic [8*((2*POSITION_WIDTH+8+7)/8)-1:0]  m_axis_tdata,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [pths_pkg::CFG_ADDR_WIDTH-1:0]      cfg_addr,
    input  logic [pths_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

    localparam int PW       = POSITION_WIDTH;
    localparam int OUT_BITS = 2 * PW + 8;
    localparam int OUT_DW   = 8 * ((OUT_BITS + 7) / 8);

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_H_START   = 4'd1,
        ST_H_TOUCH   = 4'd2,
        ST_H_RETRACT = 4'd3,
        ST_M_START   = 4'd4,
        ST_M_TOUCH   = 4'd5,
        ST_M_RETRACT = 4'd6,
        ST_ALARM     = 4'd7,
        ST_DONE      = 4'd8,
        ST_MS_START  = 4'd9,
        ST_MS_WAIT   = 4'd10,
        ST_MS_FLASH  = 4'd11,
        ST_MS_END    = 4'd12
    } step_t;

    logic [pths_pkg::CFG_DATA_WIDTH-1:0] timeout_reg;
    logic [pths_pkg::TOL_WIDTH-1:0]      tol_reg;
    logic [pths_pkg::CFG_DATA_WIDTH-1:0] settle_reg;

    logic                                in_valid_reg;
    logic [pths_pkg::KIND_WIDTH-1:0]     in_kind_reg;
    logic signed [PW-1:0]                in_abs_reg;
    logic signed [PW-1:0]                in_rel_reg;
    logic signed [PW-1:0]                in_mm_reg;
    logic [pths_pkg::MODE_WIDTH-1:0]     in_mode_reg;
    logic                                in_fidle_reg;

    step_t                               step_reg, step_next;
    logic [TIMER_WIDTH-1:0]              timer_reg, timer_next;
    logic signed [PW-1:0]                last_reg, last_next;
    logic signed [PW-1:0]                first_reg, first_next;
    logic                                count_reg, count_next;
    logic                                drive_reg, drive_next;
    logic                                done_reg, done_next;
    logic                                alarm_reg, alarm_next;

    logic                                out_valid_reg;
    logic [OUT_BITS-1:0]                 out_reg, out_next;

    logic [pths_pkg::TARGET_WIDTH-1:0]   target;
    logic signed [PW-1:0]                spos;
    logic signed [PW-1:0]                smm;
    logic                                save;
    logic [pths_pkg::MODE_REQ_WIDTH-1:0] mode_req;

    logic [TIMER_WIDTH-1:0]              timer_dec;
    logic signed [PW:0]                  touch_diff;
    logic [PW:0]                         touch_mag;
    logic                                touch_bad;
    logic                                out_free;
    logic                                advance;

    function automatic logic [TIMER_WIDTH-1:0] timer_load(
        input logic [pths_pkg::CFG_DATA_WIDTH-1:0] v
    );
        logic [TIMER_WIDTH+pths_pkg::CFG_DATA_WIDTH-1:0] ext;
        ext = {{TIMER_WIDTH{1'b0}}, v};
        return ext[TIMER_WIDTH-1:0];
    endfunction

    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DW'(out_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= pths_pkg::TIMEOUT_TICKS_RESET;
            tol_reg     <= pths_pkg::TOUCH_TOL_RESET;
            settle_reg  <= pths_pkg::MEASURE_SETTLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                pths_pkg::REG_TIMEOUT_TICKS:  timeout_reg <= cfg_data;
                pths_pkg::REG_TOUCH_TOL:      tol_reg <= cfg_data[pths_pkg::TOL_WIDTH-1:0];
                pths_pkg::REG_MEASURE_SETTLE: settle_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    assign timer_dec  = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
    assign touch_diff = {in_abs_reg[PW-1], in_abs_reg} - {first_reg[PW-1], first_reg};
    assign touch_mag  = touch_diff[PW] ? $unsigned(-touch_diff) : $unsigned(touch_diff);
    assign touch_bad  = touch_mag > {{(PW + 1 - pths_pkg::TOL_WIDTH){1'b0}}, tol_reg};

    always_comb
    begin
        step_next  = step_reg;
        timer_next = timer_reg;
        last_next  = last_reg;
        first_next = first_reg;
        count_next = count_reg;
        drive_next = drive_reg;
        done_next  = done_reg;
        alarm_next = alarm_reg;
        target     = pths_pkg::TARGET_NONE;
        spos       = '0;
        smm        = '0;
        save       = 1'b0;
        mode_req   = pths_pkg::MODE_REQ_NONE;

        case (in_kind_reg)
            pths_pkg::KIND_HOME:       step_next = ST_H_START;
            pths_pkg::KIND_SEARCH_MIN: step_next = ST_M_START;
            pths_pkg::KIND_MEASURE:    step_next = ST_MS_START;
            pths_pkg::KIND_RESET:
            begin
                step_next  = ST_IDLE;
                drive_next = 1'b0;
            end
            pths_pkg::KIND_INIT:
            begin
                step_next = ST_IDLE;
                done_next = 1'b0;
            end
            pths_pkg::KIND_TICK:
            begin
                timer_next = timer_dec;
                case (step_reg)
                    ST_H_START, ST_M_START:
                    begin
                        if (step_reg == ST_H_START)
                        begin
                            done_next = 1'b0;
                        end
                        drive_next = 1'b1;
                        step_next  = (step_reg == ST_H_START) ? ST_H_TOUCH : ST_M_TOUCH;
                        count_next = 1'b0;
                        last_next  = in_abs_reg;
                        alarm_next = 1'b0;
                        timer_next = timer_load(timeout_reg);
                    end
                    ST_H_TOUCH, ST_M_TOUCH:
                    begin
                        if (timer_dec == '0)
                        begin
                            if (last_reg == in_abs_reg)
                            begin
                                if (!count_reg)
                                begin
                                    first_next = last_reg;
                                    step_next  = (step_reg == ST_H_TOUCH) ? ST_H_RETRACT
                                                                          : ST_M_RETRACT;
                                    drive_next = 1'b0;
                                    count_next = 1'b1;
                                end
                                else if (touch_bad)
                                begin
                                    step_next  = ST_ALARM;
                                    alarm_next = 1'b1;
                                    drive_next = 1'b0;
                                end
                                else
                                begin
                                    if (step_reg == ST_H_TOUCH)
                                    begin
                                        target = pths_pkg::TARGET_ZERO_OFFSET;
                                        spos   = in_abs_reg;
                                    end
                                    else
                                    begin
                                        target = pths_pkg::TARGET_MIN_POS;
                                        spos   = in_rel_reg;
                                    end
                                    step_next  = ST_DONE;
                                    alarm_next = 1'b0;
                                end
                            end
                            timer_next = timer_load(timeout_reg);
                            last_next  = in_abs_reg;
                        end
                    end
                    ST_H_RETRACT, ST_M_RETRACT:
                    begin
                        if (timer_dec == '0 && in_abs_reg >= last_reg)
                        begin
                            drive_next = 1'b1;
                            timer_next = timer_load(timeout_reg);
                            step_next  = (step_reg == ST_H_RETRACT) ? ST_H_TOUCH : ST_M_TOUCH;
                        end
                    end
                    ST_DONE:
                    begin
                        if (timer_dec == '0)
                        begin
                            drive_next = 1'b0;
                            done_next  = 1'b1;
                        end
                    end
                    ST_MS_START:
                    begin
                        drive_next = 1'b1;
                        timer_next = timer_load(settle_reg);
                        last_next  = in_rel_reg;
                        step_next  = ST_MS_WAIT;
                    end
                    ST_MS_WAIT:
                    begin
                        if (timer_dec == '0)
                        begin
                            if (last_reg == in_rel_reg)
                            begin
                                if (in_mode_reg == pths_pkg::MODE_SELF_LEARN)
                                begin
                                    target    = pths_pkg::TARGET_MOULD_DEPTH;
                                    spos      = in_abs_reg;
                                    smm       = in_mm_reg;
                                    save      = 1'b1;
                                    step_next = ST_MS_FLASH;
                                end
                                else if (in_mode_reg == pths_pkg::MODE_CALIBRATION)
                                begin
                                    target    = pths_pkg::TARGET_MIN_POS;
                                    spos      = in_abs_reg;
                                    save      = 1'b1;
                                    step_next = ST_MS_FLASH;
                                end
                                else
                                begin
                                    step_next = ST_MS_END;
                                end
                            end
                            timer_next = timer_load(timeout_reg);
                            last_next  = in_rel_reg;
                        end
                    end
                    ST_MS_FLASH:
                    begin
                        if (in_fidle_reg)
                        begin
                            if (in_mode_reg == pths_pkg::MODE_SELF_LEARN)
                            begin
                                mode_req = pths_pkg::MODE_REQ_SELF_LEARN;
                            end
                            else if (in_mode_reg == pths_pkg::MODE_CALIBRATION)
                            begin
                                mode_req = pths_pkg::MODE_REQ_CALIBRATION;
                            end
                            step_next = ST_MS_END;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        out_next = {mode_req, save, smm, spos, target, alarm_next, done_next, drive_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_kind_reg   <= pths_pkg::KIND_TICK;
            in_abs_reg    <= '0;
            in_rel_reg    <= '0;
            in_mm_reg     <= '0;
            in_mode_reg   <= '0;
            in_fidle_reg  <= 1'b0;
            step_reg      <= ST_IDLE;
            timer_reg     <= '0;
            last_reg      <= '0;
            first_reg     <= '0;
            count_reg     <= 1'b0;
            drive_reg     <= 1'b0;
            done_reg      <= 1'b0;
            alarm_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
                in_kind_reg  <= s_axis_tuser;
                in_abs_reg   <= s_axis_tdata[PW-1:0];
                in_rel_reg   <= s_axis_tdata[2*PW-1:PW];
                in_mm_reg    <= s_axis_tdata[3*PW-1:2*PW];
                in_mode_reg  <= s_axis_tdata[3*PW+1:3*PW];
                in_fidle_reg <= s_axis_tdata[3*PW+2];
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                step_reg      <= step_next;
                timer_reg     <= timer_next;
                last_reg      <= last_next;
                first_reg     <= first_next;
                count_reg     <= count_next;
                drive_reg     <= drive_next;
                done_reg      <= done_next;
                alarm_reg     <= alarm_next;
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_alarm_retracted: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == ST_ALARM |-> !drive_reg)
        else $error("probe extended while in alarm step");

    a_depth_saves: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg[4:3] == pths_pkg::TARGET_MOULD_DEPTH |-> out_reg[2*PW+5])
        else $error("mould depth stored without save request");

    a_mode_req_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg[2*PW+7:2*PW+6] != pths_pkg::MODE_REQ_NONE
        |-> out_reg[4:3] == pths_pkg::TARGET_NONE && !out_reg[2*PW+5])
        else $error("mode request issued together with a store");

    a_stage_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled while a stage is free");

endmodule
